@@ rtl/ttw_pkg.sv @@
// Package for the text terminal writer: payload structs, constants, SGR color table.
// No dependencies.
`default_nettype none
package ttw_pkg;
    localparam int TERMINALS_D = 8;
    localparam int LINES_D     = 128;
    localparam int COLUMNS_D   = 80;
    localparam int MAX_ARGS_D  = 4;

    localparam logic [7:0] ATTR_DEFAULT = 8'h0F;
    localparam logic [7:0] CH_NUL = 8'h00;
    localparam logic [7:0] CH_BS  = 8'h08;
    localparam logic [7:0] CH_TAB = 8'h09;
    localparam logic [7:0] CH_LF  = 8'h0A;
    localparam logic [7:0] CH_ESC = 8'h1B;
    localparam logic [7:0] CH_SP  = 8'h20;
    localparam logic [7:0] CH_LBR = 8'h5B;
    localparam logic [7:0] CH_QT  = 8'h22;
    localparam logic [7:0] CH_SEMI = 8'h3B;
    localparam logic [7:0] CH_J   = 8'h4A;
    localparam logic [7:0] CH_M   = 8'h6D;

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_ESC  = 2'd1;
    localparam logic [1:0] PH_CSI  = 2'd2;
    localparam logic [1:0] PH_STR  = 2'd3;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_READ  = 1'b1;

    typedef struct packed {
        logic        operation;
        logic [2:0]  terminal;
        logic [7:0]  byte_in;
        logic [13:0] cell_address;
    } t_req;

    typedef struct packed {
        logic        echo_valid;
        logic [7:0]  echo_byte;
        logic        attribute_valid;
        logic [7:0]  attribute_out;
        logic        clear_screen;
        logic [13:0] cursor_out;
        logic [15:0] cell_data;
    } t_rsp;

    function automatic logic [2:0] sgr_color(input logic [2:0] i);
        case (i)
            3'd0: sgr_color = 3'd0;
            3'd1: sgr_color = 3'd4;
            3'd2: sgr_color = 3'd2;
            3'd3: sgr_color = 3'd6;
            3'd4: sgr_color = 3'd1;
            3'd5: sgr_color = 3'd5;
            3'd6: sgr_color = 3'd3;
            default: sgr_color = 3'd7;
        endcase
    endfunction

    // One SGR argument applied to an attribute.
    function automatic logic [7:0] sgr_apply(input logic [7:0] a, input logic [7:0] v);
        logic [7:0] r;
        r = a;
        if (v == 8'd0) r = ATTR_DEFAULT;
        else if (v == 8'd1) r = a | 8'h08;
        else if (v == 8'd2) r = a & 8'hF7;
        else if (v == 8'd5) r = a | 8'h80;
        else if (v >= 8'd30 && v <= 8'd37) r = (a & 8'hF8) | {5'd0, sgr_color(v[2:0] - 3'd6)};
        else if (v >= 8'd40 && v <= 8'd47) r = (a & 8'h8F) | {1'b0, sgr_color(v[2:0]), 4'd0};
        sgr_apply = r;
    endfunction
endpackage
`default_nettype wire

@@ rtl/ttw_cell_ram.sv @@
// Cell memory: one write port, one registered read port.
// Depends on nothing.
`default_nettype none
module ttw_cell_ram #(
    parameter int AW = 17
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [15:0]   i_wdata,
    input  wire logic [AW-1:0] i_raddr,
    output logic [15:0]        o_rdata
);
    logic [15:0] mem [0:(1<<AW)-1];
    always_ff @(posedge i_clk) begin
        if (i_we) mem[i_waddr] <= i_wdata;
        o_rdata <= mem[i_raddr];
    end
endmodule
`default_nettype wire

@@ rtl/text_terminal_writer_core.sv @@
// Text terminal writer top level: request sequencer, per-terminal state, cell memory.
// Depends on ttw_pkg and ttw_cell_ram.
//
//   channel | direction | handshake             | payload
//   request | in        | i_valid / o_stall     | i_req  (t_req)
//   result  | out       | o_valid / i_stall     | o_rsp  (t_rsp)
//   config  | in        | i_cfg_we              | i_cfg_data (active terminal)
//
// Fills write one cell at a time: up to 8 for tab, up to COLUMNS for newline, every cell
// for a clear; backspace then walks back over the cells, reading each one and then checking it.
// The result waits in o_rsp on i_stall; a new request is accepted only once it has been taken.
// Reset: a clearing pass writes zero over all 2^(TW+CW) words, with TW = ceil(log2 TERMINALS),
// at least 1, and CW = ceil(log2 CELLS) (131072 words by default), while o_stall stays high.
`default_nettype none
module text_terminal_writer_core
    import ttw_pkg::*;
#(
    parameter int TERMINALS = TERMINALS_D,
    parameter int LINES     = LINES_D,
    parameter int COLUMNS   = COLUMNS_D,
    parameter int MAX_ARGS  = MAX_ARGS_D
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_stall,
    input  wire t_req       i_req,
    output logic            o_valid,
    input  wire logic       i_stall,
    output t_rsp            o_rsp,
    input  wire logic       i_cfg_we,
    input  wire logic [2:0] i_cfg_data
);
    localparam int CELLS = LINES * COLUMNS;
    localparam int CW    = $clog2(CELLS);
    localparam int TW    = (TERMINALS > 1) ? $clog2(TERMINALS) : 1;
    localparam int AW    = TW + CW;
    localparam int KW    = $clog2(MAX_ARGS + 1);
    localparam int AIW   = (MAX_ARGS > 1) ? $clog2(MAX_ARGS) : 1;
    // Line number of the cursor by reciprocal multiplication.
    localparam int     DSH  = CW + 8;
    localparam longint DMUL = ((longint'(1) << DSH) + longint'(COLUMNS) - 1) / longint'(COLUMNS);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_CLR   = 4'd1;
    localparam logic [3:0] S_RD    = 4'd2;
    localparam logic [3:0] S_RDW   = 4'd3;
    localparam logic [3:0] S_FILL  = 4'd4;
    localparam logic [3:0] S_BSRD  = 4'd5;
    localparam logic [3:0] S_BSCHK = 4'd6;
    localparam logic [3:0] S_SGR   = 4'd7;
    localparam logic [3:0] S_DONE  = 4'd8;
    localparam logic [3:0] S_OUT   = 4'd9;

    logic [3:0] r_state;
    logic [2:0] r_active;

    // Small per-terminal state registers.
    logic [CW-1:0] r_cursor [TERMINALS];
    logic [7:0]    r_attr   [TERMINALS];
    logic [1:0]    r_phase  [TERMINALS];
    logic [7:0]    r_args   [TERMINALS][MAX_ARGS];
    logic [KW-1:0] r_argc   [TERMINALS];

    t_req          r_req;
    logic [TW-1:0] r_t;
    logic [AW-1:0] r_sweep;
    logic [CW-1:0] r_p;
    logic [CW:0]   r_end;
    logic [CW-1:0] r_q;
    logic [15:0]   r_fill;
    logic [KW-1:0] r_n;
    logic [7:0]    r_a;
    t_rsp          r_rsp;
    logic          r_ovalid;

    logic          we;
    logic [AW-1:0] waddr, raddr;
    logic [15:0]   wdata, rdata;

    ttw_cell_ram #(.AW(AW)) u_ram (
        .i_clk(i_clk), .i_we(we), .i_waddr(waddr), .i_wdata(wdata),
        .i_raddr(raddr), .o_rdata(rdata)
    );

    wire        t_ok   = ({1'b0, i_req.terminal} < 4'(TERMINALS));
    wire        accept = i_valid && !o_stall;
    wire [7:0]  b      = r_req.byte_in;
    wire        act    = (r_req.terminal == r_active);
    wire [CW-1:0] cur  = r_cursor[r_t];
    wire [7:0]  attr   = r_attr[r_t];
    wire [CW-1:0] in_cur = r_cursor[TW'(i_req.terminal)];
    wire [CW+DSH-1:0] lf_prod = (CW+DSH)'(in_cur) * (CW+DSH)'(DMUL);

    assign o_stall = (r_state != S_IDLE) || r_ovalid;
    assign o_valid = r_ovalid;
    assign o_rsp   = r_rsp;

    function automatic logic [CW-1:0] wrap(input logic [CW:0] p);
        wrap = (p >= (CW+1)'(CELLS)) ? CW'(p - (CW+1)'(CELLS)) : p[CW-1:0];
    endfunction

    always_comb begin
        we    = 1'b0;
        waddr = {r_t, r_p};
        wdata = r_fill;
        raddr = {r_t, r_p};
        unique case (r_state)
            S_CLR: begin
                we = 1'b1; waddr = r_sweep; wdata = 16'd0;
            end
            S_FILL: begin
                we = ({1'b0, r_p} < r_end) && ({1'b0, r_p} < (CW+1)'(CELLS));
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLR;
            r_sweep  <= '0;
            r_active <= 3'd0;
            r_ovalid <= 1'b0;
            for (int t = 0; t < TERMINALS; t++) begin
                r_cursor[t] <= '0;
                r_attr[t]   <= ATTR_DEFAULT;
                r_phase[t]  <= PH_IDLE;
                r_argc[t]   <= '0;
                for (int k = 0; k < MAX_ARGS; k++) r_args[t][k] <= 8'd0;
            end
        end else begin
            if (i_cfg_we) r_active <= i_cfg_data;
            if (r_ovalid && !i_stall) r_ovalid <= 1'b0;
            unique case (r_state)
                S_CLR: begin
                    r_sweep <= r_sweep + 1'b1;
                    if (&r_sweep) r_state <= S_IDLE;
                end
                S_IDLE: if (accept) begin
                    r_req <= i_req;
                    r_t   <= TW'(i_req.terminal);
                    r_rsp <= '{cursor_out: (t_ok ? 14'(in_cur) : 14'd0), default: '0};
                    r_q   <= CW'(lf_prod >> DSH);
                    if (!t_ok) r_state <= S_OUT;
                    else if (i_req.operation == OP_READ) begin
                        r_p     <= CW'(i_req.cell_address);
                        r_state <= S_RD;
                    end else begin
                        r_p     <= in_cur;
                        r_state <= S_DONE;
                    end
                end
                S_RD: r_state <= S_RDW;
                S_RDW: begin
                    r_rsp.cursor_out <= 14'(cur);
                    r_rsp.cell_data  <= (32'(r_req.cell_address) < 32'(CELLS)) ? rdata : 16'd0;
                    r_state <= S_OUT;
                end
                S_DONE: begin
                    // Decode the written byte against the terminal's parser phase.
                    logic [3:0] n_state;
                    n_state = S_OUT;
                    case (r_phase[r_t])
                        PH_ESC: begin
                            if (b == CH_LBR) begin
                                r_phase[r_t] <= PH_CSI;
                                r_argc[r_t]  <= '0;
                                for (int k = 0; k < MAX_ARGS; k++) r_args[r_t][k] <= 8'd0;
                            end else r_phase[r_t] <= PH_IDLE;
                        end
                        PH_STR: if (b == CH_QT) r_phase[r_t] <= PH_IDLE;
                        PH_CSI: begin
                            if (b >= 8'h30 && b <= 8'h39) begin
                                if (r_argc[r_t] < KW'(MAX_ARGS)) begin
                                    logic [11:0] v;
                                    v = 12'(r_args[r_t][AIW'(r_argc[r_t])]) * 12'd10
                                        + 12'(b - 8'h30);
                                    r_args[r_t][AIW'(r_argc[r_t])] <=
                                        (v > 12'd255) ? 8'hFF : v[7:0];
                                end
                            end else if (b == CH_SEMI) begin
                                if (r_argc[r_t] < KW'(MAX_ARGS))
                                    r_argc[r_t] <= r_argc[r_t] + 1'b1;
                            end else if (b == CH_QT) r_phase[r_t] <= PH_STR;
                            else begin
                                r_phase[r_t] <= PH_IDLE;
                                if (b == CH_J && r_args[r_t][0] == 8'd2) begin
                                    r_p <= '0; r_end <= (CW+1)'(CELLS);
                                    r_fill <= {attr, CH_SP};
                                    r_cursor[r_t] <= '0;
                                    r_rsp.cursor_out <= '0;
                                    r_rsp.clear_screen <= act;
                                    n_state = S_FILL;
                                end else if (b == CH_M) begin
                                    r_n <= (r_argc[r_t] < KW'(MAX_ARGS)) ?
                                           r_argc[r_t] + 1'b1 : KW'(MAX_ARGS);
                                    r_a <= attr;
                                    n_state = S_SGR;
                                end
                            end
                        end
                        default: begin
                            r_rsp.echo_valid <= act && b != CH_NUL && b != CH_ESC;
                            r_rsp.echo_byte  <= (act && b != CH_NUL && b != CH_ESC) ? b : 8'd0;
                            if (b == CH_ESC) r_phase[r_t] <= PH_ESC;
                            else if (b == CH_BS) begin
                                r_p <= cur; r_end <= {1'b0, cur} + 1'b1;
                                r_fill <= {attr, CH_SP};
                                n_state = S_FILL;
                            end else if (b == CH_TAB) begin
                                r_end <= ({1'b0, cur} + (CW+1)'(8)) & ~(CW+1)'(7);
                                r_fill <= {attr, 8'd0};
                                n_state = S_FILL;
                            end else if (b == CH_LF) begin
                                r_end <= ({1'b0, r_q} + 1'b1) * (CW+1)'(COLUMNS);
                                r_fill <= {attr, 8'd0};
                                n_state = S_FILL;
                            end else if (b >= CH_SP) begin
                                r_p <= cur; r_end <= {1'b0, cur} + 1'b1;
                                r_fill <= {attr, b};
                                n_state = S_FILL;
                            end
                        end
                    endcase
                    r_state <= n_state;
                end
                S_FILL: begin
                    // Write one cell a cycle to the stop, then place the cursor or walk back.
                    if ({1'b0, r_p} + 1'b1 < r_end && r_p < CW'(CELLS - 1))
                        r_p <= r_p + 1'b1;
                    else if (r_rsp.clear_screen || (r_phase[r_t] == PH_IDLE
                             && b == CH_J && r_req.operation == OP_WRITE
                             && r_fill[7:0] == CH_SP && r_end == (CW+1)'(CELLS)
                             && r_rsp.cursor_out == 14'd0 && !r_rsp.echo_valid
                             && r_req.byte_in == CH_J)) begin
                        r_state <= S_OUT;
                    end else if (b == CH_BS) begin
                        if (cur == '0) r_state <= S_OUT;
                        else begin
                            r_p <= cur - 1'b1;
                            r_state <= S_BSRD;
                        end
                    end else if (b == CH_TAB || b == CH_LF) begin
                        logic [CW-1:0] np;
                        np = wrap(r_end);
                        r_cursor[r_t] <= np;
                        r_rsp.cursor_out <= 14'(np);
                        r_state <= S_OUT;
                    end else begin
                        logic [CW-1:0] np;
                        np = wrap({1'b0, cur} + 1'b1);
                        r_cursor[r_t] <= np;
                        r_rsp.cursor_out <= 14'(np);
                        r_state <= S_OUT;
                    end
                end
                S_BSRD: r_state <= S_BSCHK;
                S_BSCHK: begin
                    if (rdata[7:0] == 8'd0 && r_p != '0) begin
                        r_p <= r_p - 1'b1;
                        r_state <= S_BSRD;
                    end else begin
                        r_cursor[r_t] <= r_p + 1'b1;
                        r_rsp.cursor_out <= 14'(r_p + 1'b1);
                        r_state <= S_OUT;
                    end
                end
                S_SGR: begin
                    // Apply arguments last first, one a cycle.
                    if (r_n == '0) begin
                        r_attr[r_t] <= r_a;
                        r_rsp.attribute_valid <= act;
                        r_rsp.attribute_out   <= act ? r_a : 8'd0;
                        r_state <= S_OUT;
                    end else begin
                        r_a <= sgr_apply(r_a, r_args[r_t][AIW'(r_n - 1'b1)]);
                        r_n <= r_n - 1'b1;
                    end
                end
                S_OUT: begin
                    r_ovalid <= 1'b1;
                    r_state  <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire
